>>> design/assert_macros.svh
// Assertion macros for the text console RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/tcc_pkg.sv
// Types and constants for the text console with cursor and scrolling.
// No dependencies; used by tcc_engine and text_console_cursor_scroll.
package tcc_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;
  localparam logic [6:0] COLUMNS_RESET    = 7'd80;
  localparam logic [4:0] ROWS_RESET       = 5'd25;

  localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] CFG_COLUMNS    = 2'd1;
  localparam logic [1:0] CFG_ROWS       = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } request_t;

  typedef struct packed {
    logic [7:0] text_color;
    logic [6:0] cols;
    logic [4:0] rows;
  } console_cfg_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } response_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } engine_status_t;

endpackage

>>> design/tcc_engine.sv
// Sequencer and cell store of the text console: put, scroll, clear and read.
// Depends on tcc_pkg; the cell store is a one-write, one-read synchronous memory.
module tcc_engine #(
  parameter int MAX_COLS     = 80,
  parameter int MAX_ROWS     = 25,
  parameter int DEFAULT_ATTR = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tcc_pkg::request_t      req,
  input  tcc_pkg::console_cfg_t  cfg,
  input  logic                   res_take,
  output tcc_pkg::engine_status_t stat,
  output tcc_pkg::response_t     res
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tcc_pkg::state_t   state, state_next;
  tcc_pkg::request_t req_q;

  logic [6:0]    cursor_col;
  logic [4:0]    cursor_row;
  logic [4:0]    rd_row;
  logic [6:0]    rd_col;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] copy_addr;
  logic          copy_pend;
  logic [7:0]    cell_char;
  logic [7:0]    cell_attr;

  logic [15:0]   mem [DEPTH];
  logic [15:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Step decode for the item held in req_q.
  logic [7:0]    col_adv;
  logic [5:0]    row_adv;
  logic          is_newline;
  logic          take_line;
  logic          need_scroll;
  logic          cursor_in_store;
  logic          read_hit;
  logic          sweep_last;
  logic          scroll_col_last;
  logic          scroll_row_last;
  logic [AW-1:0] cursor_addr;
  logic [AW-1:0] read_addr;
  logic [AW-1:0] scroll_addr;
  logic [AW-1:0] fill_addr;

  always_comb begin
    col_adv         = {1'b0, cursor_col} + 8'd1;
    row_adv         = {1'b0, cursor_row} + 6'd1;
    is_newline      = (req_q.char_code == tcc_pkg::NEWLINE_CODE);
    take_line       = is_newline || (col_adv >= {1'b0, cfg.cols});
    need_scroll     = take_line && (row_adv >= {1'b0, cfg.rows});
    cursor_in_store = (int'(cursor_col) < MAX_COLS) && (int'(cursor_row) < MAX_ROWS);
    read_hit        = (req_q.read_col < cfg.cols) && (req_q.read_row < cfg.rows);
    sweep_last      = (sweep_addr == AW'(DEPTH - 1));
    scroll_col_last = (rd_col == cfg.cols - 7'd1);
    scroll_row_last = (rd_row == cfg.rows - 5'd1);
    cursor_addr     = AW'(int'(cursor_row) * MAX_COLS + int'(cursor_col));
    read_addr       = AW'(int'(req_q.read_row) * MAX_COLS + int'(req_q.read_col));
    scroll_addr     = AW'(int'(rd_row) * MAX_COLS + int'(rd_col));
    fill_addr       = AW'(int'(cfg.rows - 5'd1) * MAX_COLS + int'(rd_col));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tcc_pkg::ST_INIT: begin
        if (sweep_last) state_next = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        if (start) state_next = tcc_pkg::ST_EXEC;
      end
      tcc_pkg::ST_EXEC: begin
        unique case (req_q.op)
          tcc_pkg::OP_PUT: begin
            if (!need_scroll) state_next = tcc_pkg::ST_RESULT;
            else if (cfg.rows == 5'd1) state_next = tcc_pkg::ST_FILL;
            else state_next = tcc_pkg::ST_SCROLL;
          end
          tcc_pkg::OP_CLEAR: state_next = tcc_pkg::ST_CLEAR;
          tcc_pkg::OP_READ:  state_next = read_hit ? tcc_pkg::ST_READ : tcc_pkg::ST_RESULT;
          tcc_pkg::OP_NONE:  state_next = tcc_pkg::ST_RESULT;
          default:           state_next = tcc_pkg::ST_RESULT;
        endcase
      end
      tcc_pkg::ST_SCROLL: begin
        if (scroll_col_last && scroll_row_last) state_next = tcc_pkg::ST_FILL;
      end
      tcc_pkg::ST_FILL: begin
        if (!copy_pend && scroll_col_last) state_next = tcc_pkg::ST_RESULT;
      end
      tcc_pkg::ST_CLEAR: begin
        if (sweep_last) state_next = tcc_pkg::ST_RESULT;
      end
      tcc_pkg::ST_READ:   state_next = tcc_pkg::ST_RESULT;
      tcc_pkg::ST_RESULT: begin
        if (res_take) state_next = tcc_pkg::ST_IDLE;
      end
      default: state_next = tcc_pkg::ST_INIT;
    endcase
  end

  // Memory port selection and status outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = {8'(DEFAULT_ATTR), tcc_pkg::SPACE_CODE};
    mem_raddr = scroll_addr;
    stat.ready     = (state == tcc_pkg::ST_IDLE);
    stat.res_valid = (state == tcc_pkg::ST_RESULT);
    // A copy read in the previous cycle lands before anything else is written.
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = mem_rdata;
    end else begin
      unique case (state)
        tcc_pkg::ST_INIT, tcc_pkg::ST_CLEAR: begin
          mem_we = 1'b1;
        end
        tcc_pkg::ST_EXEC: begin
          mem_we    = (req_q.op == tcc_pkg::OP_PUT) && !is_newline && cursor_in_store;
          mem_waddr = cursor_addr;
          mem_wdata = {cfg.text_color, req_q.char_code};
        end
        tcc_pkg::ST_FILL: begin
          mem_we    = 1'b1;
          mem_waddr = fill_addr;
          mem_wdata = {cfg.text_color, tcc_pkg::SPACE_CODE};
        end
        tcc_pkg::ST_IDLE, tcc_pkg::ST_SCROLL, tcc_pkg::ST_READ,
        tcc_pkg::ST_RESULT: begin
          mem_we = 1'b0;
        end
        default: mem_we = 1'b0;
      endcase
    end
    if (state == tcc_pkg::ST_EXEC) mem_raddr = read_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcc_pkg::ST_INIT;
      sweep_addr <= '0;
      copy_pend  <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      state     <= state_next;
      copy_pend <= (state == tcc_pkg::ST_SCROLL);
      if (start && state == tcc_pkg::ST_IDLE) req_q <= req;

      unique case (state)
        tcc_pkg::ST_INIT, tcc_pkg::ST_CLEAR: begin
          sweep_addr <= sweep_last ? '0 : sweep_addr + AW'(1);
        end
        tcc_pkg::ST_EXEC: begin
          sweep_addr <= '0;
          rd_row     <= 5'd1;
          rd_col     <= '0;
          cell_char  <= '0;
          cell_attr  <= '0;
          if (req_q.op == tcc_pkg::OP_PUT) begin
            if (take_line) begin
              cursor_col <= '0;
              cursor_row <= need_scroll ? cfg.rows - 5'd1 : row_adv[4:0];
            end else begin
              cursor_col <= col_adv[6:0];
            end
          end
        end
        tcc_pkg::ST_SCROLL: begin
          // The row read now is written one row higher in the next cycle.
          copy_addr <= scroll_addr - AW'(MAX_COLS);
          if (scroll_col_last) begin
            rd_col <= '0;
            rd_row <= rd_row + 5'd1;
          end else begin
            rd_col <= rd_col + 7'd1;
          end
        end
        tcc_pkg::ST_FILL: begin
          if (!copy_pend) rd_col <= rd_col + 7'd1;
        end
        tcc_pkg::ST_READ: begin
          cell_char <= mem_rdata[7:0];
          cell_attr <= mem_rdata[15:8];
        end
        tcc_pkg::ST_IDLE, tcc_pkg::ST_RESULT: begin
          sweep_addr <= sweep_addr;
        end
        default: sweep_addr <= '0;
      endcase
    end
  end

  assign res.cursor_col = cursor_col;
  assign res.cursor_row = cursor_row;
  assign res.cell_char  = cell_char;
  assign res.cell_attr  = cell_attr;

endmodule

>>> design/text_console_cursor_scroll.sv
// Top level of the text console: configuration registers, request intake and
// the response register. Depends on tcc_pkg, tcc_engine and assert_macros.svh.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   request  | req_valid / req_stall     | operation, char_code, read_col, read_row
//   response | rsp_valid / rsp_stall     | cursor_col, cursor_row, cell_char, cell_attr
//   config   | cfg_we                    | cfg_index, cfg_data
//
// A printed character, newline without scroll, read or no-op passes the execute
// state, the read state for a read inside the area, and the result state; a scroll
// copies each row in use up by one and blanks the last (only blanking when a single
// row is in use), one cell per cycle through the single write port. Clear walks all
// MAX_COLS*MAX_ROWS cells, one per cycle. After reset the same walk fills the store
// before the first request is taken. One request is in flight at a time; a finished
// response waits in its register while the next request is accepted.
module text_console_cursor_scroll #(
  parameter int MAX_COLS     = 80,
  parameter int MAX_ROWS     = 25,
  parameter int DEFAULT_ATTR = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  input  logic [6:0] read_col,
  input  logic [4:0] read_row,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  `include "assert_macros.svh"

  logic [7:0] text_color;
  logic [6:0] columns;
  logic [4:0] rows;

  tcc_pkg::console_cfg_t   cfg;
  tcc_pkg::request_t       req;
  tcc_pkg::response_t      res;
  tcc_pkg::engine_status_t stat;

  logic start;
  logic slot_free;
  logic res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcc_pkg::TEXT_COLOR_RESET;
      columns    <= tcc_pkg::COLUMNS_RESET;
      rows       <= tcc_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcc_pkg::CFG_TEXT_COLOR: text_color <= cfg_data;
        tcc_pkg::CFG_COLUMNS:    columns    <= cfg_data[6:0];
        tcc_pkg::CFG_ROWS:       rows       <= cfg_data[4:0];
        default:                 text_color <= text_color;
      endcase
    end
  end

  // Zero acts as one; values beyond the store act as its size.
  always_comb begin
    cfg.text_color = text_color;
    priority if (columns == 7'd0)          cfg.cols = 7'd1;
    else if (int'(columns) > MAX_COLS)     cfg.cols = 7'(MAX_COLS);
    else                                   cfg.cols = columns;
    priority if (rows == 5'd0)             cfg.rows = 5'd1;
    else if (int'(rows) > MAX_ROWS)        cfg.rows = 5'(MAX_ROWS);
    else                                   cfg.rows = rows;
  end

  assign req.op        = tcc_pkg::op_t'(operation);
  assign req.char_code = char_code;
  assign req.read_col  = read_col;
  assign req.read_row  = read_row;

  assign req_stall = !stat.ready;
  assign start     = req_valid && stat.ready;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign res_take  = stat.res_valid && slot_free;

  tcc_engine #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .DEFAULT_ATTR (DEFAULT_ATTR)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .cfg      (cfg),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      cursor_col <= res.cursor_col;
      cursor_row <= res.cursor_row;
      cell_char  <= res.cell_char;
      cell_attr  <= res.cell_attr;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `ASSERT_NEXT(a_result_lands, clk, rst, res_take, rsp_valid)
  `ASSERT_IMPLIES(a_cursor_in_store, clk, rst, rsp_valid,
                  (int'(cursor_col) < MAX_COLS) && (int'(cursor_row) < MAX_ROWS))

endmodule

>>> test/testbench.sv
// Self-checking testbench for text_console_cursor_scroll: random and directed requests
// are checked against a cell-store shadow kept by a small scoreboard class.
// Depends on tcc_pkg and the text_console_cursor_scroll RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int MAX_COLS        = 80;
  localparam int MAX_ROWS        = 25;
  localparam int DEFAULT_ATTR    = 7;
  localparam int RANDOM_REQUESTS = 850;
  localparam int CYCLE_LIMIT     = 6_000_000;

  logic       clk;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] operation = '0;
  logic [7:0] char_code = '0;
  logic [6:0] read_col  = '0;
  logic [4:0] read_row  = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  text_console_cursor_scroll #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .DEFAULT_ATTR (DEFAULT_ATTR)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .char_code  (char_code),
    .read_col   (read_col),
    .read_row   (read_row),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  class console_shadow;
    logic [15:0] cells [MAX_ROWS][MAX_COLS];
    int unsigned col_pos;
    int unsigned line_pos;
    logic [7:0]  color;
    logic [6:0]  cols_reg;
    logic [4:0]  rows_reg;
    response_t   due_responses[$];
    int          failures;
    int          checked;
    int          scrolls;
    int          clears;

    function new();
      fill_blank();
      col_pos  = 0;
      line_pos = 0;
      color    = TEXT_COLOR_RESET;
      cols_reg = COLUMNS_RESET;
      rows_reg = ROWS_RESET;
      failures = 0;
      checked  = 0;
      scrolls  = 0;
      clears   = 0;
    endfunction

    function void fill_blank();
      for (int r = 0; r < MAX_ROWS; r++)
        for (int c = 0; c < MAX_COLS; c++)
          cells[r][c] = {8'(DEFAULT_ATTR), SPACE_CODE};
    endfunction

    // Out-of-range register values are clamped to 1 and to the store size.
    function int unsigned cols_in_use();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function int unsigned rows_in_use();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function void put_cell(int unsigned c, int unsigned r, logic [15:0] v);
      if (c < MAX_COLS && r < MAX_ROWS) cells[r][c] = v;
    endfunction

    function void scroll_up();
      int unsigned nc;
      int unsigned nr;
      nc = cols_in_use();
      nr = rows_in_use();
      for (int unsigned r = 0; r + 1 < nr; r++)
        for (int unsigned c = 0; c < nc; c++)
          cells[r][c] = cells[r + 1][c];
      for (int unsigned c = 0; c < nc; c++)
        put_cell(c, nr - 1, {color, SPACE_CODE});
      scrolls++;
    endfunction

    function void advance_line();
      col_pos  = 0;
      line_pos = line_pos + 1;
      if (line_pos >= rows_in_use()) begin
        line_pos = rows_in_use() - 1;
        scroll_up();
      end
    endfunction

    function void write_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_TEXT_COLOR: color = data;
        CFG_COLUMNS: cols_reg = data[6:0];
        CFG_ROWS: rows_reg = data[4:0];
        default: ;
      endcase
    endfunction

    function void apply_request(request_t req);
      response_t exp;
      exp = '0;
      case (req.op)
        OP_PUT: begin
          if (req.char_code == NEWLINE_CODE) begin
            advance_line();
          end else begin
            // The write lands even when the cursor sits outside a shrunk area.
            put_cell(col_pos, line_pos, {color, req.char_code});
            col_pos = col_pos + 1;
            if (col_pos >= cols_in_use()) advance_line();
          end
        end
        OP_CLEAR: begin
          fill_blank();
          clears++;
        end
        OP_READ: begin
          if (req.read_col < cols_in_use() && req.read_row < rows_in_use())
            {exp.cell_attr, exp.cell_char} = cells[req.read_row][req.read_col];
        end
        default: ;
      endcase
      exp.cursor_col = col_pos[6:0];
      exp.cursor_row = line_pos[4:0];
      due_responses.push_back(exp);
    endfunction

    function void compare_response(response_t got);
      response_t exp;
      if (due_responses.size() == 0) begin
        $error("response with no request outstanding: col %0d row %0d char %0d attr %0d",
               got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr);
        failures++;
        return;
      end
      exp = due_responses.pop_front();
      checked++;
      if (got.cursor_col !== exp.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", exp.cursor_col, got.cursor_col);
        failures++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", exp.cursor_row, got.cursor_row);
        failures++;
      end
      if (got.cell_char !== exp.cell_char) begin
        $error("cell_char: expected %0d, got %0d", exp.cell_char, got.cell_char);
        failures++;
      end
      if (got.cell_attr !== exp.cell_attr) begin
        $error("cell_attr: expected %0d, got %0d", exp.cell_attr, got.cell_attr);
        failures++;
      end
    endfunction
  endclass

  console_shadow shadow;
  int            settings_used = 0;
  bit            steady        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: random back-pressure, none during the steady stretch.
  always @(negedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      shadow.compare_response(response_t'{cursor_col, cursor_row, cell_char, cell_attr});
  end

  task automatic send(op_t op, logic [7:0] ch, logic [6:0] rc, logic [4:0] rr);
    request_t req;
    req.op        = op;
    req.char_code = ch;
    req.read_col  = rc;
    req.read_row  = rr;
    while (!steady && $urandom_range(99) < 35) begin
      @(negedge clk);
      req_valid = 1'b0;
    end
    @(negedge clk);
    req_valid = 1'b1;
    operation = op;
    char_code = ch;
    read_col  = rc;
    read_row  = rr;
    do @(posedge clk); while (req_stall);
    shadow.apply_request(req);
  endtask

  // Hold off new requests until every outstanding response has been checked.
  task automatic settle();
    @(negedge clk);
    req_valid = 1'b0;
    while (shadow.due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    shadow.write_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("text_console_cursor_scroll: mismatch");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned nc;
    int unsigned nr;
    int unsigned phase_len;
    int unsigned pick;
    logic [7:0]  ch;
    logic [6:0]  rc;
    logic [4:0]  rr;
    logic [6:0]  new_cols;
    logic [4:0]  new_rows;
    op_t         op;

    shadow = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default 80x25 area: printing, reads at the corners and beyond, no-op, clear.
    send(OP_PUT, 8'h48, '0, '0);
    send(OP_PUT, 8'hFF, '0, '0);
    send(OP_PUT, 8'h00, '0, '0);
    send(OP_READ, 8'h00, 7'd0, 5'd0);
    send(OP_READ, 8'h00, 7'd2, 5'd0);
    send(OP_READ, 8'h00, 7'd79, 5'd24);
    send(OP_READ, 8'h00, 7'd80, 5'd0);
    send(OP_READ, 8'h00, 7'd0, 5'd25);
    send(OP_READ, 8'h00, 7'd127, 5'd31);
    send(OP_NONE, 8'hFF, 7'd127, 5'd31);
    send(OP_PUT, NEWLINE_CODE, '0, '0);
    send(OP_PUT, 8'h78, '0, '0);
    send(OP_PUT, 8'h79, '0, '0);
    send(OP_CLEAR, 8'h00, '0, '0);
    send(OP_READ, 8'h00, 7'd0, 5'd0);

    // Zero-sized registers act as a 1x1 area while the cursor sits outside it.
    settle();
    set_register(CFG_TEXT_COLOR, 8'hFF);
    set_register(CFG_COLUMNS, 8'd0);
    set_register(CFG_ROWS, 8'd0);
    settings_used++;
    send(OP_PUT, 8'h5A, '0, '0);
    send(OP_READ, 8'h00, 7'd0, 5'd1);
    send(OP_READ, 8'h00, 7'd0, 5'd0);
    send(OP_PUT, NEWLINE_CODE, '0, '0);

    // Oversized registers clamp to the full store; the earlier write is visible again.
    settle();
    set_register(CFG_TEXT_COLOR, 8'h00);
    set_register(CFG_COLUMNS, 8'd127);
    set_register(CFG_ROWS, 8'd31);
    settings_used++;
    send(OP_READ, 8'h00, 7'd2, 5'd1);
    send(OP_PUT, 8'h7F, '0, '0);
    send(OP_READ, 8'h00, 7'd0, 5'd0);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      settle();
      case ($urandom_range(9))
        0: new_cols = 7'd0;
        1: new_cols = 7'd80;
        2: new_cols = 7'd127;
        3: new_cols = 7'($urandom_range(11, 127));
        default: new_cols = 7'($urandom_range(1, 10));
      endcase
      case ($urandom_range(9))
        0: new_rows = 5'd0;
        1: new_rows = 5'd25;
        2: new_rows = 5'd31;
        3: new_rows = 5'($urandom_range(6, 31));
        default: new_rows = 5'($urandom_range(1, 5));
      endcase
      set_register(CFG_TEXT_COLOR, 8'($urandom_range(255)));
      set_register(CFG_COLUMNS, {1'b0, new_cols});
      set_register(CFG_ROWS, {3'b000, new_rows});
      settings_used++;
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
        steady = (sent >= 300 && sent < 450);
        nc   = shadow.cols_in_use();
        nr   = shadow.rows_in_use();
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        rc   = 7'($urandom_range(127));
        rr   = 5'($urandom_range(31));
        if (pick < 58) begin
          op = OP_PUT;
          if ($urandom_range(4) == 0) ch = NEWLINE_CODE;
        end else if (pick < 93) begin
          op = OP_READ;
          // Most reads land inside the area in use; the rest anywhere.
          if ($urandom_range(4) != 0) begin
            rc = 7'($urandom_range(nc - 1));
            rr = 5'($urandom_range(nr - 1));
          end
        end else if (pick < 96) begin
          op = OP_CLEAR;
        end else begin
          op = OP_NONE;
        end
        send(op, ch, rc, rr);
        sent++;
      end
    end
    steady = 1'b0;

    settle();
    repeat (20) @(posedge clk);

    $display("Checked %0d responses over %0d register settings, with %0d scrolls and %0d clears.",
             shadow.checked, settings_used, shadow.scrolls, shadow.clears);
    if (shadow.failures == 0 && shadow.due_responses.size() == 0) begin
      $display("text_console_cursor_scroll: match");
    end else begin
      $display("text_console_cursor_scroll: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/tcc_pkg.sv
design/tcc_engine.sv
design/text_console_cursor_scroll.sv
test/testbench.sv
